>>> rtl/byte_ring_buffer_segments_core_macros.svh
// Assertion macros for the byte ring buffer with segments.
// Used by byte_ring_buffer_segments_core; needs a clock named clk and a reset named rst.
`ifndef BYTE_RING_BUFFER_SEGMENTS_CORE_MACROS_SVH
`define BYTE_RING_BUFFER_SEGMENTS_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BRBS_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ring buffer same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BRBS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ring buffer next-cycle check failed");

`endif

>>> rtl/brbs_pkg.sv
// Package for the byte ring buffer with segments: field widths, status codes
// and sequencer states. No dependencies.
package brbs_pkg;

  localparam int DATA_W = 8;
  localparam int LEN_W  = 6;
  localparam int STAT_W = 3;

  typedef enum logic [STAT_W-1:0] {
    ST_PUSHED    = 3'd0,
    ST_POPPED    = 3'd1,
    ST_ZERO_LEN  = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_NO_DATA   = 3'd4,
    ST_BUSY      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP_RD,
    S_POP_OUT
  } state_t;

endpackage

>>> rtl/brbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module brbs_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/byte_ring_buffer_segments_core.sv
// Byte ring buffer with one guard slot; push segments stored all or nothing.
// Single-result items: captured on acceptance, checked in S_EXEC, result registered
// there; S_EXEC waits while the output register is full. Items are taken only in S_IDLE.
// Pop of n bytes: each byte takes an S_POP_RD state for the registered RAM read and
// an S_POP_OUT state that registers it, waiting while the output is full.
// Synchronous active-high reset clears pointers, counts, segment state and output valid.
`include "byte_ring_buffer_segments_core_macros.svh"

module byte_ring_buffer_segments_core #(
  parameter int RING_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] write_byte, [13:8] length, [15:14] zero
  input  logic        s_axis_tuser,  // [0] operation: 0 push byte, 1 pop request
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] read_byte, [13:8] used_bytes,
                                     // [19:14] free_bytes, [23:20] zero
  output logic [2:0]  m_axis_tuser,  // [2:0] status
  output logic        m_axis_tlast   // last result of the input item
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(RING_DEPTH - 1);
  localparam int LEN_W  = brbs_pkg::LEN_W;
  localparam int DATA_W = brbs_pkg::DATA_W;

  // Sequencer and ring state.
  brbs_pkg::state_t state, state_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] used, used_next;        // bytes held, at most RING_DEPTH-1
  logic [LEN_W-1:0] seg_rem, seg_rem_next;  // bytes of the open segment still to come
  logic             seg_rej, seg_rej_next;  // open segment is being dropped
  logic [LEN_W-1:0] pop_rem, pop_rem_next;  // bytes of the current pop still to send

  // Captured input item.
  logic              in_op, in_op_next;
  logic [DATA_W-1:0] in_byte, in_byte_next;
  logic [LEN_W-1:0]  in_len, in_len_next;

  // Output register.
  logic              out_valid, out_valid_next;
  brbs_pkg::status_t out_status, out_status_next;
  logic [DATA_W-1:0] out_byte, out_byte_next;
  logic              out_last, out_last_next;
  logic [LEN_W-1:0]  out_used, out_used_next;

  // Ring memory ports.
  logic              ram_we, ram_re;
  logic [DATA_W-1:0] ram_rdata;

  // Shared compare unit and helpers.
  logic [PTR_W-1:0] space;
  logic [LEN_W-1:0] cmp_a;
  logic             cmp_lt;
  logic             out_free_slot;
  logic             seg_first;
  logic [LEN_W-1:0] rem_eff;
  logic             rej_eff;
  logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
  logic [PTR_W-1:0] ptr_span;

  assign space      = PTR_MAX - used;
  // One comparator serves both checks: free space for a push, held bytes for a pop.
  assign cmp_a      = in_op ? LEN_W'(used) : LEN_W'(space);
  assign cmp_lt     = cmp_a < in_len;
  assign wr_ptr_inc = (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_inc = (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
  assign seg_first  = (seg_rem == '0);
  assign rem_eff    = seg_first ? in_len : seg_rem;
  assign rej_eff    = seg_first ? cmp_lt : seg_rej;
  assign out_free_slot = !out_valid || m_axis_tready;

  // Distance between the pointers; must always agree with the fill count.
  assign ptr_span = (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr
                                       : wr_ptr - rd_ptr + PTR_W'(RING_DEPTH);

  brbs_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (in_byte),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brbs_pkg::S_IDLE;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      used      <= '0;
      seg_rem   <= '0;
      seg_rej   <= 1'b0;
      pop_rem   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_ptr    <= rd_ptr_next;
      wr_ptr    <= wr_ptr_next;
      used      <= used_next;
      seg_rem   <= seg_rem_next;
      seg_rej   <= seg_rej_next;
      pop_rem   <= pop_rem_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    in_op      <= in_op_next;
    in_byte    <= in_byte_next;
    in_len     <= in_len_next;
    out_status <= out_status_next;
    out_byte   <= out_byte_next;
    out_last   <= out_last_next;
    out_used   <= out_used_next;
  end

  always_comb begin
    state_next      = state;
    rd_ptr_next     = rd_ptr;
    wr_ptr_next     = wr_ptr;
    used_next       = used;
    seg_rem_next    = seg_rem;
    seg_rej_next    = seg_rej;
    pop_rem_next    = pop_rem;
    in_op_next      = in_op;
    in_byte_next    = in_byte;
    in_len_next     = in_len;
    out_valid_next  = out_valid && !m_axis_tready;
    out_status_next = out_status;
    out_byte_next   = out_byte;
    out_last_next   = out_last;
    out_used_next   = out_used;
    ram_we          = 1'b0;
    ram_re          = 1'b0;

    unique case (state)
      brbs_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          in_op_next   = s_axis_tuser;
          in_byte_next = s_axis_tdata[7:0];
          in_len_next  = s_axis_tdata[13:8];
          state_next   = brbs_pkg::S_EXEC;
        end
      end

      brbs_pkg::S_EXEC: begin
        if (out_free_slot) begin
          state_next    = brbs_pkg::S_IDLE;
          out_byte_next = '0;
          out_last_next = 1'b1;
          out_used_next = LEN_W'(used);
          if (!in_op) begin
            out_valid_next = 1'b1;
            if (seg_first && in_len == '0) begin
              out_status_next = brbs_pkg::ST_ZERO_LEN;
            end else if (rej_eff) begin
              seg_rem_next    = rem_eff - 1'b1;
              seg_rej_next    = (rem_eff != LEN_W'(1));
              out_status_next = brbs_pkg::ST_NO_SPACE;
            end else begin
              seg_rem_next    = rem_eff - 1'b1;
              seg_rej_next    = 1'b0;
              ram_we          = 1'b1;
              wr_ptr_next     = wr_ptr_inc;
              used_next       = used + 1'b1;
              out_used_next   = LEN_W'(used + 1'b1);
              out_status_next = brbs_pkg::ST_PUSHED;
            end
          end else if (!seg_first) begin
            out_valid_next  = 1'b1;
            out_status_next = brbs_pkg::ST_BUSY;
          end else if (in_len == '0) begin
            out_valid_next  = 1'b1;
            out_status_next = brbs_pkg::ST_ZERO_LEN;
          end else if (cmp_lt) begin
            out_valid_next  = 1'b1;
            out_status_next = brbs_pkg::ST_NO_DATA;
          end else begin
            // Enough bytes held: stream them out one by one.
            pop_rem_next = in_len;
            state_next   = brbs_pkg::S_POP_RD;
          end
        end
      end

      brbs_pkg::S_POP_RD: begin
        ram_re     = 1'b1;
        state_next = brbs_pkg::S_POP_OUT;
      end

      brbs_pkg::S_POP_OUT: begin
        if (out_free_slot) begin
          out_valid_next  = 1'b1;
          out_status_next = brbs_pkg::ST_POPPED;
          out_byte_next   = ram_rdata;
          out_last_next   = (pop_rem == LEN_W'(1));
          out_used_next   = LEN_W'(used - 1'b1);
          used_next       = used - 1'b1;
          rd_ptr_next     = rd_ptr_inc;
          pop_rem_next    = pop_rem - 1'b1;
          state_next      = (pop_rem == LEN_W'(1)) ? brbs_pkg::S_IDLE : brbs_pkg::S_POP_RD;
        end
      end

      default: begin
        state_next = brbs_pkg::S_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state == brbs_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {4'b0000, LEN_W'(RING_DEPTH - 1) - out_used, out_used, out_byte};

  // The fill count tracks the pointer distance at all times.
  `BRBS_ASSERT_IMPL(a_used_matches_ptrs, 1'b1, used == ptr_span)
  // Every result other than a popped byte ends its item.
  `BRBS_ASSERT_IMPL(a_single_is_last,
      m_axis_tvalid && m_axis_tuser != brbs_pkg::ST_POPPED, m_axis_tlast)
  // A pop stream never runs while a push segment is open.
  `BRBS_ASSERT_IMPL(a_no_pop_in_segment,
      state == brbs_pkg::S_POP_RD || state == brbs_pkg::S_POP_OUT, seg_rem == '0)
  // A read issued for a pop is followed by the output state that delivers it.
  `BRBS_ASSERT_NEXT(a_read_then_out, state == brbs_pkg::S_POP_RD,
      state == brbs_pkg::S_POP_OUT)

endmodule
